// ===== hw/rtl/stp_pkg.sv =====
// Shared types and constants for the step/direction positioner.
// Holds the transfer item structs, per-channel lane structs and opcode codes.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

    // Opcode codes carried in the input item
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_MOVE_ABS = 3'd1;
    localparam logic [2:0] OP_MOVE_REL = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_STOP_ALL = 3'd4;

    // Configuration register indexes
    localparam logic CFG_ADDED_MASK   = 1'b0;
    localparam logic CFG_EN_HIGH_MASK = 1'b1;

    // Channels visible through the 2-bit channel field and 4-bit masks
    localparam int MAX_LANES = 4;

    // Saturation limits for relative targets
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [1:0]         channel;
        logic signed [31:0] move_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         step_levels;
        logic [3:0]         dir_levels;
        logic [3:0]         enable_levels;
        logic [3:0]         busy_mask;
        logic signed [31:0] position;
        logic               in_position;
    } t_out_item;

    // Command applied to one channel lane for one item
    typedef struct packed {
        logic        tick;
        logic        load;
        logic        stop;
        logic        dir;
        logic [31:0] mag;
    } t_lane_cmd;

    // Pin and count state of one channel lane
    typedef struct packed {
        logic        step;
        logic        dir;
        logic        en;
        logic        busy;
        logic [31:0] pos;
    } t_lane_state;

endpackage

`default_nettype wire

// ===== hw/rtl/stepper_step_dir_positioner.sv =====
// Step/direction positioner top level: input and result registers, command
// decode, channel lanes and the move distance unit. Uses stp_pkg, stp_move, stp_lane.
//
// Usage:
//  - Input channel (i_in_valid / i_in_data / o_in_stall) carries one command:
//    tick, absolute move, relative move, stop channel or stop all.
//  - Output channel (o_out_valid / o_out_data / i_out_stall) returns one status
//    item per command: pin levels and busy mask of all channels, plus position
//    and in-position flag of the addressed channel if added (else zero), all after the update.
//  - Configuration: i_cfg_we writes i_cfg_data into the added mask (index 0)
//    or the enable polarity mask (index 1). Write only while no command is
//    in flight.
//  - Path: a transferred command is held in the input register, and its result is
//    loaded into the result register when that register is free or being drained.
//  - Throughput: one command per cycle unless results stall; all lanes update in
//    parallel; move distances use a single level of 33-bit adders plus selection.
//  - Reset (synchronous, active low) clears every lane to position zero,
//    idle, clockwise, disabled; added mask becomes 1, polarity mask 0.
//  - A stalled result is held; the input register still takes one more
//    command, then o_in_stall rises until the result register frees up.
//  - Lanes beyond four are not built: channels past that range never bind.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_dir_positioner #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire stp_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output stp_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [3:0]         i_cfg_data
);
    import stp_pkg::*;

    localparam int NLANE = (NUM_CHANNELS < MAX_LANES) ? NUM_CHANNELS : MAX_LANES;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [3:0]  r_added_mask;
    logic [3:0]  r_en_high_mask;

    logic        adv;
    logic        in_accept;
    logic        is_tick;
    logic        is_move;
    logic        is_rel;
    logic        is_stop;
    logic        is_stop_all;
    logic        sel_added;
    logic [31:0] sel_pos;
    logic        mv_dir;
    logic [31:0] mv_mag;

    t_lane_cmd   lane_cmd  [NLANE];
    t_lane_state lane_cur  [NLANE];
    t_lane_state lane_next [NLANE];
    logic [NLANE-1:0][31:0] cur_pos_vec;
    logic [NLANE-1:0]       cur_busy_vec;
    logic [NLANE-1:0]       cur_en_vec;

    // Handshake: advance when the result register is free or being drained
    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold payloads; no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_added_mask   <= 4'd1;
            r_en_high_mask <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDED_MASK:   r_added_mask   <= i_cfg_data;
                CFG_EN_HIGH_MASK: r_en_high_mask <= i_cfg_data;
                default:          r_added_mask   <= r_added_mask;
            endcase
        end
    end

    // Decode the opcode
    always_comb begin
        is_tick     = 1'b0;
        is_move     = 1'b0;
        is_rel      = 1'b0;
        is_stop     = 1'b0;
        is_stop_all = 1'b0;
        unique case (r_in.opcode)
            OP_TICK:     is_tick     = 1'b1;
            OP_MOVE_ABS: is_move     = 1'b1;
            OP_MOVE_REL: begin
                is_move = 1'b1;
                is_rel  = 1'b1;
            end
            OP_STOP:     is_stop     = 1'b1;
            OP_STOP_ALL: is_stop_all = 1'b1;
            default:     is_tick     = 1'b0;
        endcase
    end

    // Select the addressed lane
    always_comb begin
        sel_added = 1'b0;
        sel_pos   = 32'd0;
        for (int i = 0; i < NLANE; i++) begin
            if (r_in.channel == 2'(i)) begin
                sel_added = r_added_mask[i];
                sel_pos   = lane_cur[i].pos;
            end
        end
    end

    stp_move u_move (
        .i_relative (is_rel),
        .i_value    (r_in.move_value),
        .i_cur_pos  (sel_pos),
        .o_dir      (mv_dir),
        .o_mag      (mv_mag)
    );

    // Build per-lane commands
    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            lane_cmd[i].tick = is_tick && r_added_mask[i];
            lane_cmd[i].load = is_move && r_added_mask[i] && (r_in.channel == 2'(i));
            lane_cmd[i].stop = r_added_mask[i] &&
                               (is_stop_all || (is_stop && (r_in.channel == 2'(i))));
            lane_cmd[i].dir  = mv_dir;
            lane_cmd[i].mag  = mv_mag;
        end
    end

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        stp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cmd   (lane_cmd[g]),
            .o_cur   (lane_cur[g]),
            .o_next  (lane_next[g])
        );
        assign cur_pos_vec[g]  = lane_cur[g].pos;
        assign cur_busy_vec[g] = lane_cur[g].busy;
        assign cur_en_vec[g]   = lane_cur[g].en;
    end

    // Assemble the status item from the updated lane state
    always_comb begin
        n_out = '0;
        for (int i = 0; i < NLANE; i++) begin
            n_out.step_levels[i]   = lane_next[i].step;
            n_out.dir_levels[i]    = lane_next[i].dir;
            n_out.enable_levels[i] = ~(lane_next[i].en ^ r_en_high_mask[i]);
            n_out.busy_mask[i]     = lane_next[i].busy;
            if (sel_added && (r_in.channel == 2'(i))) begin
                n_out.position    = lane_next[i].pos;
                n_out.in_position = !lane_next[i].busy;
            end
        end
    end

`ifndef SYNTHESIS
    // A processed command always lands in the result register
    a_adv_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register not loaded after advance");

    // A blocked command stays in the input register
    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input register dropped a blocked command");

    // A channel with steps left is always enabled
    a_busy_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_busy_vec & ~cur_en_vec) == '0)
        else $error("busy channel without enable");

    // Positions move only on a processed tick
    a_pos_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && is_tick) |=> $stable(cur_pos_vec))
        else $error("position changed without a tick");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/stp_move.sv =====
// Move distance unit: direction and step count for absolute or relative moves.
// Pure combinational; uses stp_pkg for the saturation constants.
`timescale 1ns / 1ps
`default_nettype none

module stp_move (
    input  wire logic        i_relative,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_cur_pos,
    output logic             o_dir,
    output logic [31:0]      o_mag
);
    import stp_pkg::*;

    logic [32:0] diff_tc;   // target - current
    logic [32:0] diff_ct;   // current - target
    logic [32:0] rel_sum;   // current + offset
    logic [31:0] neg_value;
    logic        rel_ovf;
    logic [31:0] sat_neg_mag;

    // Run the three adders side by side, then pick
    assign diff_tc   = {i_value[31], i_value} - {i_cur_pos[31], i_cur_pos};
    assign diff_ct   = {i_cur_pos[31], i_cur_pos} - {i_value[31], i_value};
    assign rel_sum   = {i_cur_pos[31], i_cur_pos} + {i_value[31], i_value};
    assign neg_value = 32'd0 - i_value;
    assign rel_ovf   = rel_sum[32] != rel_sum[31];

    // Distance to the lower limit when the target clips negative
    assign sat_neg_mag = i_cur_pos ^ SIGN_BIT;

    always_comb begin
        if (!i_relative) begin
            o_dir = diff_tc[32];
            o_mag = diff_tc[32] ? diff_ct[31:0] : diff_tc[31:0];
        end else if (!rel_ovf) begin
            // Target in range: distance is the offset itself
            o_dir = i_value[31];
            o_mag = i_value[31] ? neg_value : i_value;
        end else if (!rel_sum[32]) begin
            // Clipped to the upper limit
            o_dir = 1'b0;
            o_mag = ~i_cur_pos ^ (POS_MAX ^ 32'hFFFF_FFFF);
        end else begin
            // Clipped to the lower limit
            o_dir = |sat_neg_mag;
            o_mag = sat_neg_mag;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stp_lane.sv =====
// One channel lane: step count, position and step/dir/enable pin registers.
// Applies tick, load and stop commands; depends on stp_pkg for lane structs.
`timescale 1ns / 1ps
`default_nettype none

module stp_lane (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire stp_pkg::t_lane_cmd   i_cmd,
    output stp_pkg::t_lane_state      o_cur,
    output stp_pkg::t_lane_state      o_next
);
    import stp_pkg::*;

    logic [31:0] r_steps, n_steps;
    logic [31:0] r_pos,   n_pos;
    logic        r_step,  n_step;
    logic        r_dir,   n_dir;
    logic        r_en,    n_en;

    // Work out the lane update for the item in flight
    always_comb begin
        n_steps = r_steps;
        n_pos   = r_pos;
        n_step  = r_step;
        n_dir   = r_dir;
        n_en    = r_en;
        if (i_adv) begin
            if (i_cmd.tick) begin
                if (r_steps == 32'd0) begin
                    n_step = 1'b0;
                end else if (!r_step) begin
                    n_step = 1'b1;
                end else begin
                    // Falling edge of the step pin completes one step
                    n_step  = 1'b0;
                    n_steps = r_steps - 32'd1;
                    n_pos   = r_dir ? (r_pos - 32'd1) : (r_pos + 32'd1);
                end
            end
            if (i_cmd.load) begin
                n_dir   = i_cmd.dir;
                n_steps = i_cmd.mag;
                if (i_cmd.mag != 32'd0) begin
                    n_en = 1'b1;
                end
            end
            if (i_cmd.stop) begin
                n_steps = 32'd0;
                n_en    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= 32'd0;
            r_pos   <= 32'd0;
            r_step  <= 1'b0;
            r_dir   <= 1'b0;
            r_en    <= 1'b0;
        end else begin
            r_steps <= n_steps;
            r_pos   <= n_pos;
            r_step  <= n_step;
            r_dir   <= n_dir;
            r_en    <= n_en;
        end
    end

    assign o_cur  = '{step: r_step, dir: r_dir, en: r_en,
                      busy: (r_steps != 32'd0), pos: r_pos};
    assign o_next = '{step: n_step, dir: n_dir, en: n_en,
                      busy: (n_steps != 32'd0), pos: n_pos};

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the step/direction positioner.
// Drives commands with random gaps and result stalls; a local lane model predicts each
// status transfer. Depends on stp_pkg and stepper_step_dir_positioner.
`timescale 1ns / 1ps

module tb_top;
    import stp_pkg::*;

    // Opcodes the block treats as no-ops
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam int QUIET_LIMIT = 2000;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = 1'b0;
    logic [3:0] cfg_data = 4'd0;

    // Lane model: state after every accepted command
    logic [31:0] lane_pos [MAX_LANES];
    logic [31:0] lane_steps [MAX_LANES];
    logic        lane_step_pin [MAX_LANES];
    logic        lane_dir [MAX_LANES];
    logic        lane_en [MAX_LANES];
    logic [3:0]  cfg_added;
    logic [3:0]  cfg_en_high;

    t_out_item expected_status [$];
    int        fail_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    stepper_step_dir_positioner #(
        .NUM_CHANNELS(4)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- lane model

    function automatic void clear_lanes();
        cfg_added = 4'd1;
        cfg_en_high = 4'd0;
        for (int k = 0; k < MAX_LANES; k++) begin
            lane_pos[k] = '0;
            lane_steps[k] = '0;
            lane_step_pin[k] = 1'b0;
            lane_dir[k] = 1'b0;
            lane_en[k] = 1'b0;
        end
    endfunction

    // Load direction and step count toward a target position
    function automatic void aim_lane(int ch, longint target);
        longint span;
        span = target - longint'($signed(lane_pos[ch]));
        if (span >= 0) begin
            lane_dir[ch] = 1'b0;
        end else begin
            lane_dir[ch] = 1'b1;
            span = -span;
        end
        lane_steps[ch] = span[31:0];
        if (lane_steps[ch] != 0) begin
            lane_en[ch] = 1'b1;
        end
    endfunction

    function automatic void halt_lane(int ch);
        if (cfg_added[ch]) begin
            lane_steps[ch] = '0;
            lane_en[ch] = 1'b0;
        end
    endfunction

    // Apply one command to the lanes and build the status it returns
    function automatic t_out_item predict_status(t_in_item cmd);
        t_out_item res;
        longint target;
        int ch;
        res = '0;
        ch = int'(cmd.channel);
        case (cmd.opcode)
            OP_TICK: begin
                for (int k = 0; k < MAX_LANES; k++) begin
                    if (!cfg_added[k]) begin
                        continue;
                    end
                    if (lane_steps[k] == 0) begin
                        lane_step_pin[k] = 1'b0;
                    end else if (!lane_step_pin[k]) begin
                        lane_step_pin[k] = 1'b1;
                    end else begin
                        // falling edge: one step taken
                        lane_step_pin[k] = 1'b0;
                        lane_steps[k] = lane_steps[k] - 1;
                        lane_pos[k] = lane_dir[k] ? lane_pos[k] - 1 : lane_pos[k] + 1;
                    end
                end
            end
            OP_MOVE_ABS: begin
                if (cfg_added[ch]) begin
                    aim_lane(ch, longint'(cmd.move_value));
                end
            end
            OP_MOVE_REL: begin
                if (cfg_added[ch]) begin
                    target = longint'($signed(lane_pos[ch])) + longint'(cmd.move_value);
                    if (target > SAT_HI) begin
                        target = SAT_HI;
                    end
                    if (target < SAT_LO) begin
                        target = SAT_LO;
                    end
                    aim_lane(ch, target);
                end
            end
            OP_STOP: begin
                halt_lane(ch);
            end
            OP_STOP_ALL: begin
                for (int k = 0; k < MAX_LANES; k++) begin
                    halt_lane(k);
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < MAX_LANES; k++) begin
            res.step_levels[k] = lane_step_pin[k];
            res.dir_levels[k] = lane_dir[k];
            res.enable_levels[k] = cfg_en_high[k] ? lane_en[k] : ~lane_en[k];
            res.busy_mask[k] = (lane_steps[k] != 0);
        end
        if (cfg_added[ch]) begin
            res.position = lane_pos[ch];
            res.in_position = (lane_steps[ch] == 0);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v,
                     act_v);
        end
    endtask

    // Compare each status transfer with the oldest prediction, then record new commands
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_status.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected status, expected none, got %h", $time,
                         o_out_data);
            end else begin
                exp_item = expected_status.pop_front();
                report_field("step_levels", 32'(exp_item.step_levels),
                             32'(o_out_data.step_levels));
                report_field("dir_levels", 32'(exp_item.dir_levels),
                             32'(o_out_data.dir_levels));
                report_field("enable_levels", 32'(exp_item.enable_levels),
                             32'(o_out_data.enable_levels));
                report_field("busy_mask", 32'(exp_item.busy_mask),
                             32'(o_out_data.busy_mask));
                report_field("position", exp_item.position, o_out_data.position);
                report_field("in_position", 32'(exp_item.in_position),
                             32'(o_out_data.in_position));
            end
        end
        if (rst_n && in_valid && !o_in_stall) begin
            expected_status.push_back(predict_status(in_data));
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Hold off results in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        if (!idle_on) begin
            stall_left = 0;
        end
        out_stall <= (stall_left > 0);
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_cmd(t_in_item cmd);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= cmd;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_op(logic [2:0] op, logic [1:0] ch, logic signed [31:0] val);
        t_in_item cmd;
        cmd.opcode = op;
        cmd.channel = ch;
        cmd.move_value = val;
        send_cmd(cmd);
    endtask

    // Drop valid and wait until every status has come back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [3:0] val);
        drain();
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ADDED_MASK) begin
            cfg_added = val;
        end else begin
            cfg_en_high = val;
        end
    endtask

    // Mostly ticks, with moves, stops, wild values and no-op codes mixed in
    function automatic t_in_item random_cmd();
        t_in_item cmd;
        int sel;
        cmd.channel = 2'($urandom_range(0, 3));
        cmd.move_value = $urandom;
        cmd.opcode = OP_TICK;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            cmd.opcode = OP_TICK;
        end else if (sel < 70) begin
            cmd.opcode = OP_MOVE_REL;
            cmd.move_value = int'($urandom_range(0, 40)) - 20;
        end else if (sel < 80) begin
            cmd.opcode = OP_MOVE_ABS;
            cmd.move_value = lane_pos[cmd.channel] + (int'($urandom_range(0, 30)) - 15);
        end else if (sel < 85) begin
            cmd.opcode = $urandom_range(0, 1) ? OP_MOVE_ABS : OP_MOVE_REL;
        end else if (sel < 91) begin
            cmd.opcode = OP_STOP;
        end else if (sel < 94) begin
            cmd.opcode = OP_STOP_ALL;
        end else begin
            cmd.opcode = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        end
        return cmd;
    endfunction

    // ---------------------------------------------------------------- tests

    // Reset values: only channel zero bound, all enables active low
    task automatic test_reset_defaults();
        send_op(OP_TICK, 2'd0, 32'sd0);
        send_op(OP_MOVE_ABS, 2'd1, 32'sd5);
        send_op(OP_STOP, 2'd2, 32'sd0);
        send_op(OP_RSVD_LO, 2'd0, -32'sd1);
        send_op(OP_RSVD_HI, 2'd3, 32'sh7FFF_FFFF);
    endtask

    // Moves, stops and the range edges on all four channels
    task automatic test_directed_moves();
        write_cfg(CFG_ADDED_MASK, 4'hF);
        write_cfg(CFG_EN_HIGH_MASK, 4'b0101);
        send_op(OP_MOVE_ABS, 2'd0, 32'sd3);
        send_op(OP_MOVE_REL, 2'd1, -32'sd2);
        repeat (4) send_op(OP_TICK, 2'd0, 32'sd0);
        // reload while busy, step pin high
        send_op(OP_TICK, 2'd0, 32'sd0);
        send_op(OP_MOVE_ABS, 2'd0, 32'sd0);
        // stop with step pin high, then tick forces it low
        send_op(OP_MOVE_REL, 2'd2, 32'sd4);
        send_op(OP_TICK, 2'd2, 32'sd0);
        send_op(OP_STOP, 2'd2, 32'sd0);
        send_op(OP_TICK, 2'd2, 32'sd0);
        // zero-distance moves
        send_op(OP_MOVE_ABS, 2'd1, -32'sd2);
        send_op(OP_MOVE_REL, 2'd2, 32'sd0);
        // relative targets at or past the signed range edges saturate
        send_op(OP_MOVE_REL, 2'd1, 32'sh8000_0000);
        send_op(OP_MOVE_REL, 2'd2, 32'sh7FFF_FFFF);
        send_op(OP_STOP_ALL, 2'd0, 32'sd0);
        // widest absolute distances
        send_op(OP_MOVE_ABS, 2'd3, 32'sh8000_0000);
        send_op(OP_MOVE_ABS, 2'd1, 32'sh7FFF_FFFF);
        send_op(OP_TICK, 2'd3, -32'sd1);
        send_op(OP_TICK, 2'd3, -32'sd1);
        send_op(OP_STOP_ALL, 2'd3, 32'sd0);
        send_op(OP_TICK, 2'd1, 32'sd0);
    endtask

    task automatic test_random_traffic(logic [3:0] added, logic [3:0] en_high, int count);
        write_cfg(CFG_ADDED_MASK, added);
        write_cfg(CFG_EN_HIGH_MASK, en_high);
        repeat (count) send_cmd(random_cmd());
    endtask

    // Back-to-back traffic with no gaps and no result stalls
    task automatic test_steady_stream(int count);
        drain();
        idle_on = 1'b0;
        test_random_traffic(4'hF, 4'($urandom_range(0, 15)), count);
    endtask

    initial begin
        clear_lanes();
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_moves();
        test_random_traffic(4'hF, 4'hF, 150);
        test_random_traffic(4'h0, 4'h0, 40);
        test_random_traffic(4'hA, 4'h5, 130);
        test_random_traffic(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 130);
        test_random_traffic(4'hF, 4'h0, 120);
        test_steady_stream(110);
        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
